@@ hdl/ltis_pkg.sv @@
`default_nettype none

package ltis_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 4;
    localparam int FILL_W   = 5;
    localparam int KEY_W    = 64;
    localparam int AMT_W    = 32;
    localparam int WIDE_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]        name;
        logic [KEY_W-1:0]        kind;
        logic signed [AMT_W-1:0] amount;
    } record_t;

endpackage

`default_nettype wire

@@ hdl/ltis_req_if.sv @@
`default_nettype none

interface ltis_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic [ltis_pkg::KEY_W-1:0]          name_key;
    logic [ltis_pkg::KEY_W-1:0]          kind_code;
    logic signed [ltis_pkg::AMT_W-1:0]   amount;
    logic [ltis_pkg::IDX_W-1:0]          slot_index;

    modport source (
        output valid, mode, name_key, kind_code, amount, slot_index,
        input  ready
    );
    modport sink (
        input  valid, mode, name_key, kind_code, amount, slot_index,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/ltis_rsp_if.sv @@
`default_nettype none

interface ltis_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [ltis_pkg::KEY_W-1:0]          found_name;
    logic [ltis_pkg::KEY_W-1:0]          found_kind;
    logic signed [ltis_pkg::AMT_W-1:0]   found_amount;
    logic [ltis_pkg::IDX_W-1:0]          found_slot;
    logic [ltis_pkg::FILL_W-1:0]         fill_count;

    modport source (
        output valid, status, found_name, found_kind, found_amount, found_slot, fill_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_name, found_kind, found_amount, found_slot, fill_count,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/ltis_store.sv @@
`default_nettype none

// Record memory: one write port, one read port with registered read data.
module ltis_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ltis_pkg::SLOT_W-1:0] wr_addr,
    input  wire ltis_pkg::record_t           wr_rec,
    input  wire logic                        rd_en,
    input  wire logic [ltis_pkg::SLOT_W-1:0] rd_addr,
    output ltis_pkg::record_t                rd_rec
);

    ltis_pkg::record_t mem [ltis_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_rec <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/linear_table_insert_remove_search_core.sv @@
`default_nettype none

// Unsorted record table with linear search.
// req (sink): one word carries mode, name_key, kind_code, amount, slot_index.
//   insert appends a record, remove drops the first record with a matching
//   name and closes the gap, search returns the first matching record, read
//   returns the record at slot_index.
// rsp (source): one word per request with status, the found record fields,
//   found_slot and the fill count after the operation.
// One request is in flight at a time; req.ready is high only while idle.
// insert and read go straight from idle to finish; search scans the held
//   records with one compare per cycle until a match or the end; remove scans
//   to the match, then moves each later record down one slot per cycle
//   through the store's one read port and one write port.
// The memory ports and the single name comparator set this pace.
// The result sits in an output register; the next request is accepted while
// it waits, and a finished result stalls in place until rsp is free.
// Reset empties the table (fill count to zero) and drops any pending word;
// the memory itself is not cleared, since only held slots are ever read.
module linear_table_insert_remove_search_core (
    input  wire logic clk,
    input  wire logic rst_n,
    ltis_req_if.sink  req,
    ltis_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam int SLOT_W  = ltis_pkg::SLOT_W;
    localparam int COUNT_W = ltis_pkg::COUNT_W;
    localparam int IDX_W   = ltis_pkg::IDX_W;
    localparam int WIDE_W  = ltis_pkg::WIDE_W;

    state_t                            state_reg,     state_next;
    logic [COUNT_W-1:0]                count_reg,     count_next;
    logic [COUNT_W-1:0]                ptr_reg,       ptr_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]                 cmp_slot_reg,  cmp_slot_next;
    logic [ltis_pkg::KEY_W-1:0]        key_reg,       key_next;
    logic [1:0]                        mode_reg,      mode_next;
    logic [1:0]                        status_reg,    status_next;
    logic [IDX_W-1:0]                  slot_reg,      slot_next;
    logic                              use_data_reg,  use_data_next;

    logic                              out_valid_reg;
    logic [1:0]                        out_status_reg;
    ltis_pkg::record_t                 out_rec_reg;
    logic [IDX_W-1:0]                  out_slot_reg;
    logic [ltis_pkg::FILL_W-1:0]       out_fill_reg;

    logic                              mem_wr;
    logic [SLOT_W-1:0]                 wr_addr;
    ltis_pkg::record_t                 wr_rec;
    logic                              rd_en;
    logic [SLOT_W-1:0]                 rd_addr;
    ltis_pkg::record_t                 rd_rec;
    logic                              req_acc;
    logic                              out_load;

    ltis_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (wr_addr),
        .wr_rec  (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_slot_next  = cmp_slot_reg;
        key_next       = key_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        use_data_next  = use_data_reg;
        mem_wr         = 1'b0;
        wr_addr        = '0;
        wr_rec         = rd_rec;
        rd_en          = 1'b0;
        rd_addr        = SLOT_W'(ptr_reg);
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    key_next      = req.name_key;
                    mode_next     = req.mode;
                    status_next   = ltis_pkg::STAT_OK;
                    slot_next     = '0;
                    use_data_next = 1'b0;
                    case (req.mode)
                        ltis_pkg::MODE_INSERT:
                        begin
                            if (count_reg >= COUNT_W'(ltis_pkg::CAPACITY))
                            begin
                                status_next = ltis_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_wr      = 1'b1;
                                wr_addr     = SLOT_W'(count_reg);
                                wr_rec.name   = req.name_key;
                                wr_rec.kind   = req.kind_code;
                                wr_rec.amount = req.amount;
                                slot_next   = IDX_W'(count_reg);
                                count_next  = count_reg + COUNT_W'(1);
                            end
                            state_next = ST_FINISH;
                        end
                        ltis_pkg::MODE_REMOVE, ltis_pkg::MODE_SEARCH:
                        begin
                            ptr_next       = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            // read at index
                            slot_next = req.slot_index;
                            if (WIDE_W'(req.slot_index) < WIDE_W'(count_reg))
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = SLOT_W'(req.slot_index);
                                use_data_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ltis_pkg::STAT_RANGE;
                            end
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                cmp_valid_next = 1'b0;
                if (cmp_valid_reg && (rd_rec.name == key_reg))
                begin
                    slot_next = IDX_W'(cmp_slot_reg);
                    if (mode_reg == ltis_pkg::MODE_REMOVE)
                    begin
                        ptr_next   = COUNT_W'(cmp_slot_reg) + COUNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        // no read issued: rd_rec holds the match
                        use_data_next = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    ptr_next       = ptr_reg + COUNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = SLOT_W'(ptr_reg);
                end
                else if (!cmp_valid_reg)
                begin
                    status_next = ltis_pkg::STAT_MISSING;
                    state_next  = ST_FINISH;
                end
            end

            ST_SHIFT:
            begin
                cmp_valid_next = 1'b0;
                if (cmp_valid_reg)
                begin
                    mem_wr  = 1'b1;
                    wr_addr = cmp_slot_reg - SLOT_W'(1);
                    wr_rec  = rd_rec;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    ptr_next       = ptr_reg + COUNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = SLOT_W'(ptr_reg);
                end
                else if (!cmp_valid_reg)
                begin
                    count_next = count_reg - COUNT_W'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        cmp_slot_reg <= cmp_slot_next;
        key_reg      <= key_next;
        mode_reg     <= mode_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        use_data_reg <= use_data_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_rec_reg    <= use_data_reg ? rd_rec : '0;
            out_slot_reg   <= slot_reg;
            out_fill_reg   <= ltis_pkg::FILL_W'(count_reg);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_name   = out_rec_reg.name;
    assign rsp.found_kind   = out_rec_reg.kind;
    assign rsp.found_amount = out_rec_reg.amount;
    assign rsp.found_slot   = out_slot_reg;
    assign rsp.fill_count   = out_fill_reg;

    // the table never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(ltis_pkg::CAPACITY))
    else $error("record count above capacity");

    // an insert into a table with room grows it by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.mode == ltis_pkg::MODE_INSERT)
            && (count_reg < COUNT_W'(ltis_pkg::CAPACITY)))
        |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
    else $error("insert did not advance the record count");

    // while closing a gap, every write lands below the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && mem_wr) |-> (COUNT_W'(wr_addr) < ptr_reg))
    else $error("gap close wrote at or above the read pointer");

endmodule

`default_nettype wire

@@ tb/linear_table_insert_remove_search_core_test.sv @@
`timescale 1ns / 100ps

module linear_table_insert_remove_search_core_test;
    import ltis_pkg::*;

    // Pacing of the run: directed words first, then the random mix.
    localparam int RANDOM_WORDS  = 680;
    localparam int SQUEEZE_AFTER = 300;     // accepted words before the long hold-off
    localparam int SQUEEZE_LEN   = 400;     // cycles the reply side holds ready low
    localparam int TAIL_CYCLES   = 2 * CAPACITY + 20;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int POOL_SIZE     = 24;

    // One reply word as the block should present it.
    typedef struct packed {
        status_t                 status;
        logic [KEY_W-1:0]        name;
        logic [KEY_W-1:0]        kind;
        logic signed [AMT_W-1:0] amount;
        logic [IDX_W-1:0]        slot;
        logic [FILL_W-1:0]       fill;
    } table_reply_t;

    // Shadow copy of the record table. Every accepted request word updates it
    // and queues the reply the block owes; every reply word is checked
    // against the oldest one queued.
    class table_tracker;
        logic [KEY_W-1:0]        names   [CAPACITY];
        logic [KEY_W-1:0]        kinds   [CAPACITY];
        logic signed [AMT_W-1:0] amounts [CAPACITY];
        int unsigned             held;
        table_reply_t            owed_replies [$];
        int                      errors;

        function new();
            held   = 0;
            errors = 0;
            foreach (names[i])
            begin
                names[i]   = '0;
                kinds[i]   = '0;
                amounts[i] = '0;
            end
        endfunction

        // First held slot whose name equals key; lowest slot wins on duplicates.
        function bit find_first(input logic [KEY_W-1:0] key, output int unsigned slot);
            slot = 0;
            for (int unsigned i = 0; i < held && i < CAPACITY; i++)
            begin
                if (names[i] === key)
                begin
                    slot = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(input mode_t mode, input logic [KEY_W-1:0] key,
                                   input logic [KEY_W-1:0] kind,
                                   input logic signed [AMT_W-1:0] amount,
                                   input logic [IDX_W-1:0] index);
            table_reply_t r;
            int unsigned  pos;
            int unsigned  slot;
            r      = '0;
            r.status = STAT_OK;
            slot   = 0;
            case (mode)
                MODE_INSERT:
                begin
                    if (held >= CAPACITY)
                        r.status = STAT_FULL;
                    else
                    begin
                        names[held]   = key;
                        kinds[held]   = kind;
                        amounts[held] = amount;
                        slot          = held;
                        held++;
                    end
                end
                MODE_REMOVE:
                begin
                    if (!find_first(key, pos))
                        r.status = STAT_MISSING;
                    else
                    begin
                        for (int unsigned i = pos; i + 1 < held && i + 1 < CAPACITY; i++)
                        begin
                            names[i]   = names[i + 1];
                            kinds[i]   = kinds[i + 1];
                            amounts[i] = amounts[i + 1];
                        end
                        held--;
                        slot = pos;
                    end
                end
                MODE_SEARCH:
                begin
                    if (!find_first(key, pos))
                        r.status = STAT_MISSING;
                    else
                    begin
                        r.name   = names[pos];
                        r.kind   = kinds[pos];
                        r.amount = amounts[pos];
                        slot     = pos;
                    end
                end
                default:
                begin
                    slot = index;
                    if (index >= held || index >= CAPACITY)
                        r.status = STAT_RANGE;
                    else
                    begin
                        r.name   = names[index];
                        r.kind   = kinds[index];
                        r.amount = amounts[index];
                    end
                end
            endcase
            r.slot = slot[IDX_W-1:0];
            r.fill = held[FILL_W-1:0];
            owed_replies.push_back(r);
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(input string field, input logic [KEY_W-1:0] got,
                         input logic [KEY_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", field, got, want));
        endtask

        task check_reply(input table_reply_t got);
            table_reply_t want;
            if (owed_replies.size() == 0)
            begin
                report($sformatf("reply word with nothing owed: %h", got));
                return;
            end
            want = owed_replies.pop_front();
            check_field("status",       got.status, want.status);
            check_field("found_name",   got.name,   want.name);
            check_field("found_kind",   got.kind,   want.kind);
            check_field("found_amount", got.amount, want.amount);
            check_field("found_slot",   got.slot,   want.slot);
            check_field("fill_count",   got.fill,   want.fill);
        endtask
    endclass

    logic clk;
    logic rst_n;

    ltis_req_if req_bus ();
    ltis_rsp_if rsp_bus ();

    linear_table_insert_remove_search_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    table_tracker      tracker;
    int                accepted;
    int unsigned       cycles;
    bit                calm;        // both sides run without gaps while set
    bit                squeeze;     // reply side holds ready low while set
    logic [KEY_W-1:0]  name_pool [POOL_SIZE];

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold reset low from the start, then release it for good.
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: abort a hung run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [KEY_W-1:0] random_wide();
        return {$urandom(), $urandom()};
    endfunction

    // Short zero-padded text name, one to eight letters.
    function automatic logic [KEY_W-1:0] random_text_name();
        logic [KEY_W-1:0] key;
        int               len;
        key = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            key[KEY_W-1-8*i -: 8] = 8'($urandom_range(8'h41, 8'h5a));
        return key;
    endfunction

    // Offer one request word after an optional gap and hold it until accepted.
    // Keep valid high across back-to-back words; drop it only for a gap.
    task automatic offer(input mode_t mode, input logic [KEY_W-1:0] key,
                         input logic [KEY_W-1:0] kind,
                         input logic signed [AMT_W-1:0] amount,
                         input logic [IDX_W-1:0] index);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= mode;
        req_bus.name_key   <= key;
        req_bus.kind_code  <= kind;
        req_bus.amount     <= amount;
        req_bus.slot_index <= index;
        do
            @(posedge clk);
        while (!req_bus.ready);
        tracker.note_request(mode, key, kind, amount, index);
        accepted++;
    endtask

    // Name for a remove or search: usually one the table holds right now,
    // sometimes a pool name that may or may not be there.
    function automatic logic [KEY_W-1:0] lookup_name();
        if (tracker.held > 0 && $urandom_range(0, 3) != 0)
            return tracker.names[$urandom_range(0, tracker.held - 1)];
        return name_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Reply side: check each accepted reply word and pace ready with random
    // stalls. During the squeeze ready stays low so the block backs up and
    // stops taking requests.
    initial
    begin
        int           stall_left;
        table_reply_t got;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                got.status = status_t'(rsp_bus.status);
                got.name   = rsp_bus.found_name;
                got.kind   = rsp_bus.found_kind;
                got.amount = rsp_bus.found_amount;
                got.slot   = rsp_bus.found_slot;
                got.fill   = rsp_bus.fill_count;
                tracker.check_reply(got);
            end
            if (!rst_n || squeeze)
                rsp_bus.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                rsp_bus.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Long hold-off on the reply side, counted here, once the run is under way.
    initial
    begin
        squeeze <= 1'b0;
        do
            @(posedge clk);
        while (accepted < SQUEEZE_AFTER);
        squeeze <= 1'b1;
        repeat (SQUEEZE_LEN) @(posedge clk);
        squeeze <= 1'b0;
    end

    // Request side: directed words, then the random mix, then drain and verdict.
    initial
    begin
        logic [KEY_W-1:0] twin;
        logic [KEY_W-1:0] key;
        mode_t            mode;
        bit               filling;
        int               r;

        tracker  = new();
        accepted = 0;
        calm     = 1'b0;
        filling  = 1'b0;
        twin     = 64'h5457494e_00000000;

        req_bus.valid      <= 1'b0;
        req_bus.mode       <= MODE_INSERT;
        req_bus.name_key   <= '0;
        req_bus.kind_code  <= '0;
        req_bus.amount     <= '0;
        req_bus.slot_index <= '0;

        foreach (name_pool[i])
            name_pool[i] = (i % 6 == 5) ? random_wide() : random_text_name();

        do
            @(posedge clk);
        while (!rst_n);

        // Empty table: read out of range, search and remove miss.
        offer(MODE_READ,   '0,   '0, '0, 4'd0);
        offer(MODE_SEARCH, twin, '0, '0, 4'd15);
        offer(MODE_REMOVE, '1,   '1, '1, 4'd15);

        // Fill every slot: name extremes in slots 0 and 1, a duplicated name
        // in slots 2 and 9, amount and kind extremes alongside.
        for (int s = 0; s < CAPACITY; s++)
        begin
            if (s == 0)
                offer(MODE_INSERT, '0, '1, 32'sh8000_0000, 4'd15);
            else if (s == 1)
                offer(MODE_INSERT, '1, '0, 32'sh7fff_ffff, 4'd0);
            else if (s == 2 || s == 9)
                offer(MODE_INSERT, twin, random_wide(), $urandom(), 4'($urandom()));
            else
                offer(MODE_INSERT, 64'h4954454d_00000000 | s, random_wide(), $urandom(),
                      4'($urandom()));
        end

        // Full table: insert refused, duplicate resolves to the lowest slot,
        // top slot readable; then compact out of the middle and the low slots.
        offer(MODE_INSERT, random_wide(), random_wide(), $urandom(), 4'd7);
        offer(MODE_SEARCH, twin, '0, '0, 4'd0);
        offer(MODE_READ,   '0,   '0, '0, 4'd15);
        offer(MODE_REMOVE, twin, '0, '0, 4'd0);
        offer(MODE_READ,   '0,   '0, '0, 4'd15);
        offer(MODE_SEARCH, twin, '0, '0, 4'd0);
        offer(MODE_REMOVE, '1,   '0, '0, 4'd0);
        offer(MODE_REMOVE, '0,   '0, '0, 4'd0);
        offer(MODE_READ,   '0,   '0, '0, 4'd0);

        // Random mix. Alternate a filling bias and a draining bias so the table
        // swings between full and empty; a few words are pure noise.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (n % 60 == 0)
                filling = ~filling;
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                mode = mode_t'($urandom_range(0, 3));
                key  = random_wide();
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (filling)
                    mode = (r < 50) ? MODE_INSERT : (r < 65) ? MODE_REMOVE :
                           (r < 85) ? MODE_SEARCH : MODE_READ;
                else
                    mode = (r < 15) ? MODE_INSERT : (r < 60) ? MODE_REMOVE :
                           (r < 80) ? MODE_SEARCH : MODE_READ;
                if (mode == MODE_INSERT)
                    key = ($urandom_range(0, 9) == 0) ? random_wide()
                                                      : name_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = lookup_name();
            end
            offer(mode, key, random_wide(), $urandom(), 4'($urandom()));
        end

        // Drop valid, wait for every owed reply, then watch for strays.
        @(posedge clk);
        req_bus.valid <= 1'b0;
        while (tracker.owed_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.owed_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
